// ===== hw/rtl/bap_pkg.sv =====
// Shared types and constants for the bounded array block.
package bap_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int CNT_OUT_W = 6;
    localparam int CAP_W     = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DUMP   = 2'd2
    } op_t;

    // Broadcast control for the row of cells.
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [DATA_W-1:0] load_data;
    } chain_ctrl_t;

endpackage

// ===== hw/rtl/bap_cell.sv =====
// One storage cell: loads a broadcast value when addressed, else takes its neighbor on shift.
module bap_cell #(
    parameter int IDX = 0,
    parameter int IW  = 5
) (
    input  logic                       clk,
    input  bap_pkg::chain_ctrl_t       ctrl,
    input  logic [IW-1:0]              load_idx,
    input  logic [bap_pkg::DATA_W-1:0] nbr_data,
    output logic [bap_pkg::DATA_W-1:0] data_q
);
    import bap_pkg::*;

    logic [DATA_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && (load_idx == IW'(IDX)))
        begin
            data_reg <= ctrl.load_data;
        end
        else if (ctrl.shift)
        begin
            data_reg <= nbr_data;
        end
    end

    assign data_q = data_reg;

endmodule

// ===== hw/rtl/bap_chain.sv =====
// Row of cells that shifts toward cell 0 and rotates the head around to the tail.
module bap_chain #(
    parameter int DEPTH = bap_pkg::DEPTH_DEF,
    parameter int IW    = 5
) (
    input  logic                       clk,
    input  bap_pkg::chain_ctrl_t       ctrl,
    input  logic [IW-1:0]              load_idx,
    output logic [bap_pkg::DATA_W-1:0] head
);
    import bap_pkg::*;

    logic [DATA_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] nbr;
        if (i == DEPTH - 1)
        begin : g_tail
            assign nbr = cell_data[0];
        end
        else
        begin : g_mid
            assign nbr = cell_data[i+1];
        end

        bap_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .load_idx (load_idx),
            .nbr_data (nbr),
            .data_q   (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

// ===== hw/rtl/bounded_array_push_remove.sv =====
// Top level: bounded array of signed 32-bit values with push, remove-all-equal and dump.
// Push and unused codes go from idle to the response state, which loads the output register once it is free.
// Remove walks the stored elements through the cell row, one per cycle, then answers from the response state.
// Dump emits one element per cycle from the head of the cell row, while back-pressure does not hold the output.
// Requests are taken one at a time, only while the block is idle, so a walk through the cells must end first.
// Reset: count 0, capacity 32, handshakes idle; cell contents are not cleared.
module bounded_array_push_remove #(
    parameter int DEPTH = bap_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream: [1:0] operation, [33:2] item_value, [39:34] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // Result stream: [0] status, [6:1] removed_count, [12:7] element_count,
    // [44:13] element_value, [47:45] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    // Capacity write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [bap_pkg::CAP_W-1:0] cfg_data
);
    import bap_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        step_reg, step_next;   // elements still to walk
    logic [CW-1:0]        wr_reg, wr_next;       // one past the tail write slot
    op_t                  op_reg, op_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic                 rsp_status_reg, rsp_status_next;
    logic [CNT_OUT_W-1:0] rsp_rem_reg, rsp_rem_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_status_reg, out_status_next;
    logic [CNT_OUT_W-1:0] out_rem_reg, out_rem_next;
    logic [CNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [DATA_W-1:0]    out_val_reg, out_val_next;
    logic                 out_last_reg, out_last_next;

    chain_ctrl_t       ctrl;
    logic [IW-1:0]     load_idx;
    logic [DATA_W-1:0] head;

    logic       req_fire;
    logic       out_free;
    logic       full;
    logic       survive;
    op_t        req_op;
    logic [DATA_W-1:0] req_val;

    bap_chain #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_chain (
        .clk      (clk),
        .ctrl     (ctrl),
        .load_idx (load_idx),
        .head     (head)
    );

    // Configuration wins over a request in the same cycle.
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign req_fire  = s_tvalid && s_tready;
    assign req_op    = op_t'(s_tdata[1:0]);
    assign req_val   = s_tdata[33:2];

    // Output register frees when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    // Capacity above DEPTH saturates through the count == DEPTH check.
    assign full = (CMPW'(count_reg) >= CMPW'(cap_reg)) || (count_reg == CW'(DEPTH));

    // Dump keeps every element, so it is the same rotation with no drops.
    assign survive = (op_reg == OP_DUMP) || (head != val_reg);

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        wr_next         = wr_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        rsp_status_next = rsp_status_reg;
        rsp_rem_next    = rsp_rem_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_rem_next    = out_rem_reg;
        out_cnt_next    = out_cnt_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;

        ctrl.shift     = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.load_data = req_val;
        load_idx       = IW'(count_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    // A new capacity starts an empty array.
                    cap_next   = cfg_data;
                    count_next = '0;
                end
                else if (req_fire)
                begin
                    op_next         = req_op;
                    val_next        = req_val;
                    rsp_status_next = 1'b0;
                    rsp_rem_next    = '0;
                    step_next       = count_reg;
                    wr_next         = count_reg;
                    case (req_op)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                rsp_status_next = 1'b1;
                            end
                            else
                            begin
                                // Append at the slot just past the tail.
                                ctrl.load  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = ST_RESP;
                        end
                        OP_REMOVE:
                        begin
                            state_next = (count_reg == '0) ? ST_RESP : ST_RUN;
                        end
                        OP_DUMP:
                        begin
                            // Empty array dumps nothing.
                            state_next = (count_reg == '0) ? ST_IDLE : ST_RUN;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                // Walk one element per cycle; a dump waits for the output slot.
                if ((op_reg != OP_DUMP) || out_free)
                begin
                    ctrl.shift     = 1'b1;
                    ctrl.load      = survive;
                    ctrl.load_data = head;
                    load_idx       = IW'(wr_reg - CW'(1));
                    wr_next        = survive ? wr_reg : (wr_reg - CW'(1));
                    step_next      = step_reg - CW'(1);

                    if (op_reg == OP_DUMP)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = 1'b0;
                        out_rem_next    = '0;
                        out_cnt_next    = CNT_OUT_W'(count_reg);
                        out_val_next    = head;
                        out_last_next   = (step_reg == CW'(1));
                    end

                    if (step_reg == CW'(1))
                    begin
                        if (op_reg == OP_DUMP)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            // Survivors now fill cells 0 .. wr_next-1.
                            count_next   = wr_next;
                            rsp_rem_next = CNT_OUT_W'(count_reg - wr_next);
                            state_next   = ST_RESP;
                        end
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rsp_status_reg;
                    out_rem_next    = rsp_rem_reg;
                    out_cnt_next    = CNT_OUT_W'(count_reg);
                    out_val_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            step_reg      <= '0;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        rsp_status_reg <= rsp_status_next;
        rsp_rem_reg    <= rsp_rem_next;
        out_status_reg <= out_status_next;
        out_rem_reg    <= out_rem_next;
        out_cnt_reg    <= out_cnt_next;
        out_val_reg    <= out_val_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_val_reg, out_cnt_reg, out_rem_reg, out_status_reg};

    // Count never passes the row length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count exceeds depth");

    // During the walk the tail slot stays between the unwalked part and the count.
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (wr_reg <= count_reg) && (step_reg <= wr_reg)
                                  && (step_reg != '0))
        else $error("walk pointers out of order");

    // An accepted push that fits grows the array by one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req_op == OP_PUSH) && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not append");

    // A capacity write empties the array.
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (count_reg == '0))
        else $error("capacity write did not clear count");

endmodule
